// ----- rtl/core/fir_pkg.sv -----
// ----------------------------------------------------------------------------
// fir_pkg
// Shared constants, types and codes for the 16-bit direct-form FIR filter.
// ----------------------------------------------------------------------------
package fir_pkg;

  localparam int TAPS    = 256;
  localparam int AW      = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int DW      = 16;
  localparam int PROD_W  = 2 * DW;
  localparam int ACC_W   = PROD_W + AW;
  localparam int Q_SHIFT = 15;
  localparam int QW      = ACC_W - Q_SHIFT;
  localparam int TDATA_W = 40;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_WAIT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic                 hist_we;
    logic [AW-1:0]        hist_waddr;
    logic signed [DW-1:0] hist_wdata;
    logic [AW-1:0]        hist_raddr;
    logic                 coef_we;
    logic [AW-1:0]        coef_waddr;
    logic signed [DW-1:0] coef_wdata;
    logic [AW-1:0]        coef_raddr;
  } mem_req_t;

  typedef struct packed {
    logic clr;
    logic rd_v;
  } mac_ctl_t;

endpackage

// ----- rtl/core/fir_mem.sv -----
// ----------------------------------------------------------------------------
// fir_mem
// Sample history and coefficient store, one write and one registered read
// port each.
// ----------------------------------------------------------------------------
module fir_mem (
  input  logic                          clk_i,
  input  fir_pkg::mem_req_t             req_i,
  output logic signed [fir_pkg::DW-1:0] hist_rdata_o,
  output logic signed [fir_pkg::DW-1:0] coef_rdata_o
);

  logic signed [fir_pkg::DW-1:0] hist_mem [fir_pkg::TAPS];
  logic signed [fir_pkg::DW-1:0] coef_mem [fir_pkg::TAPS];

  always_ff @(posedge clk_i) begin
    if (req_i.hist_we) begin
      hist_mem[req_i.hist_waddr] <= req_i.hist_wdata;
    end
    hist_rdata_o <= hist_mem[req_i.hist_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.coef_we) begin
      coef_mem[req_i.coef_waddr] <= req_i.coef_wdata;
    end
    coef_rdata_o <= coef_mem[req_i.coef_raddr];
  end

endmodule

// ----- rtl/core/fir_mac.sv -----
// ----------------------------------------------------------------------------
// fir_mac
// Registered multiply, accumulate, then Q15 scaling with saturation.
// ----------------------------------------------------------------------------
module fir_mac (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fir_pkg::mac_ctl_t             ctl_i,
  input  logic signed [fir_pkg::DW-1:0] hist_i,
  input  logic signed [fir_pkg::DW-1:0] coef_i,
  output logic                          busy_o,
  output logic signed [fir_pkg::DW-1:0] result_o
);

  logic signed [fir_pkg::PROD_W-1:0] prod_q;
  logic                              prod_v_q;
  logic signed [fir_pkg::ACC_W-1:0]  acc_q;
  logic signed [fir_pkg::ACC_W-1:0]  biased;
  logic signed [fir_pkg::QW-1:0]     quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= ctl_i.rd_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_v) begin
      prod_q <= hist_i * coef_i;
    end
    if (ctl_i.clr) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= acc_q + fir_pkg::ACC_W'(prod_q);
    end
  end

  // divide by 2^15 rounding toward zero
  always_comb begin
    if (acc_q[fir_pkg::ACC_W-1]) begin
      biased = acc_q + $signed(fir_pkg::ACC_W'((1 << fir_pkg::Q_SHIFT) - 1));
    end else begin
      biased = acc_q;
    end
    quot = fir_pkg::QW'(biased >>> fir_pkg::Q_SHIFT);
    if (quot > $signed(fir_pkg::QW'(32767))) begin
      result_o = 16'sh7fff;
    end else if (quot < $signed(fir_pkg::QW'(-32768))) begin
      result_o = 16'sh8000;
    end else begin
      result_o = quot[fir_pkg::DW-1:0];
    end
  end

  assign busy_o = ctl_i.rd_v | prod_v_q;

endmodule

// ----- rtl/core/fir_filter_int16_unit.sv -----
// ----------------------------------------------------------------------------
// fir_filter_int16_unit
// Direct-form FIR filter, 256 taps, 16-bit samples and Q15 coefficients.
//
//   channel   dir  beat contents
//   s_axis    in   tuser: kind; tdata: sample_in, coef_index, coef_value
//   m_axis    out  tdata: sample_out
//
// A coefficient beat is written straight into its store. A sample reads
// each memory once per tap, then the multiply and accumulate stages
// drain. After reset both memories are zeroed, one entry per tap, with
// s_axis_tready low. A finished sample sits in the output register; the
// next sample may run while it waits, and only its own completion stalls
// on m_axis_tready.
// ----------------------------------------------------------------------------
module fir_filter_int16_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [15:0] sample_in, [23:16] coef_index, [39:24] coef_value
  input  logic [fir_pkg::TDATA_W-1:0]       s_axis_tdata,
  // [0] kind
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] sample_out
  output logic [fir_pkg::DW-1:0]            m_axis_tdata
);

  fir_pkg::state_e state_q, state_d;
  logic [fir_pkg::AW-1:0]        cnt_q, cnt_d;
  logic [fir_pkg::AW-1:0]        wp_q, wp_d;
  logic                          rd_v_q, rd_v_d;
  logic                          out_valid_q, out_valid_d;
  logic signed [fir_pkg::DW-1:0] out_data_q;
  logic signed [fir_pkg::DW-1:0] sample_q;

  logic                          in_beat;
  logic                          finish;
  logic                          clr;
  logic                          last_cnt;
  logic [fir_pkg::AW:0]          hsum;
  logic [fir_pkg::AW-1:0]        haddr;
  logic [31:0]                   idx_ext;
  logic signed [fir_pkg::DW-1:0] in_sample;
  logic signed [fir_pkg::DW-1:0] in_coef;
  logic signed [fir_pkg::DW-1:0] hist_rdata;
  logic signed [fir_pkg::DW-1:0] coef_rdata;
  logic signed [fir_pkg::DW-1:0] mac_result;
  logic                          mac_busy;
  fir_pkg::mem_req_t             mem_req;
  fir_pkg::mac_ctl_t             mac_ctl;

  assign in_sample = s_axis_tdata[15:0];
  assign idx_ext   = 32'(s_axis_tdata[23:16]);
  assign in_coef   = s_axis_tdata[39:24];

  assign s_axis_tready = (state_q == fir_pkg::ST_IDLE);
  assign in_beat       = s_axis_tvalid & s_axis_tready;
  assign last_cnt      = (cnt_q == fir_pkg::AW'(fir_pkg::TAPS - 1));

  // history slot of tap cnt: oldest sample first
  always_comb begin
    hsum = {1'b0, wp_q} + {1'b0, cnt_q};
    if (hsum >= (fir_pkg::AW + 1)'(fir_pkg::TAPS)) begin
      hsum = hsum - (fir_pkg::AW + 1)'(fir_pkg::TAPS);
    end
    haddr = hsum[fir_pkg::AW-1:0];
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    wp_d        = wp_q;
    rd_v_d      = 1'b0;
    finish      = 1'b0;
    clr         = 1'b0;
    mem_req     = '0;
    mem_req.hist_raddr = haddr;
    mem_req.coef_raddr = cnt_q;

    case (state_q)
      fir_pkg::ST_CLEAR: begin
        mem_req.hist_we    = 1'b1;
        mem_req.hist_waddr = cnt_q;
        mem_req.coef_we    = 1'b1;
        mem_req.coef_waddr = cnt_q;
        cnt_d = cnt_q + 1'b1;
        if (last_cnt) begin
          cnt_d   = '0;
          state_d = fir_pkg::ST_IDLE;
        end
      end
      fir_pkg::ST_IDLE: begin
        if (in_beat) begin
          if (s_axis_tuser == fir_pkg::KIND_COEF) begin
            mem_req.coef_we    = (idx_ext < 32'(fir_pkg::TAPS));
            mem_req.coef_waddr = idx_ext[fir_pkg::AW-1:0];
            mem_req.coef_wdata = in_coef;
          end else begin
            clr     = 1'b1;
            cnt_d   = '0;
            state_d = fir_pkg::ST_RUN;
          end
        end
      end
      fir_pkg::ST_RUN: begin
        rd_v_d = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (last_cnt) begin
          cnt_d   = '0;
          state_d = fir_pkg::ST_WAIT;
        end
      end
      fir_pkg::ST_WAIT: begin
        if (!mac_busy && (!out_valid_q || m_axis_tready)) begin
          finish             = 1'b1;
          mem_req.hist_we    = 1'b1;
          mem_req.hist_waddr = wp_q;
          mem_req.hist_wdata = sample_q;
          wp_d = (wp_q == fir_pkg::AW'(fir_pkg::TAPS - 1)) ? '0 : wp_q + 1'b1;
          state_d = fir_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fir_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q & ~m_axis_tready) | finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fir_pkg::ST_CLEAR;
      cnt_q       <= '0;
      wp_q        <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      wp_q        <= wp_d;
      rd_v_q      <= rd_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr) begin
      sample_q <= in_sample;
    end
    if (finish) begin
      out_data_q <= mac_result;
    end
  end

  assign mac_ctl.clr  = clr;
  assign mac_ctl.rd_v = rd_v_q;

  fir_mem u_mem (
    .clk_i        (clk_i),
    .req_i        (mem_req),
    .hist_rdata_o (hist_rdata),
    .coef_rdata_o (coef_rdata)
  );

  fir_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .hist_i   (hist_rdata),
    .coef_i   (coef_rdata),
    .busy_o   (mac_busy),
    .result_o (mac_result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
